@@ src/lldr_pkg.sv @@
// shared types and constants of the link-loss watchdog with ramp-down
// no dependencies; used by the interfaces, controller, datapath and top level
`default_nettype none

package lldr_pkg;

    localparam int unsigned DUTY_W    = 8;
    localparam int unsigned CH_FLD_W  = 3;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned STEP_W    = 8;
    localparam int unsigned PROD_W    = 2 * DUTY_W;
    // reciprocal scaling for an exact divide of a PROD_W-bit value by up to 255
    localparam int unsigned DIV_SHIFT = PROD_W + STEP_W;
    localparam int unsigned DIV_MUL_W = DIV_SHIFT + 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TIMEOUT  = 2'd0;
    localparam t_cfg_idx CFG_NOISE    = 2'd1;
    localparam t_cfg_idx CFG_INTERVAL = 2'd2;

    localparam logic [15:0] RST_TIMEOUT  = 16'd500;
    localparam logic [7:0]  RST_NOISE    = 8'd5;
    localparam logic [15:0] RST_INTERVAL = 16'd10;

    localparam logic OP_LOOP   = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TMO,
        S_RAMP,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                operation;
        logic [TIME_W-1:0]   now_ms;
        logic                got_packet;
        logic [CH_FLD_W-1:0] channel;
        logic [DUTY_W-1:0]   duty;
    } t_in_item;

    typedef struct packed {
        logic [CH_FLD_W-1:0] out_channel;
        logic [DUTY_W-1:0]   out_duty;
        logic                duty_valid;
        logic                stop_all;
        logic                safety_active;
        logic                entered_safety;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic tmo_update;
        logic ramp_step;
        logic ramp_stop;
        logic out_plain;
        logic mul;
        logic div;
        logic next_ch;
    } t_dp_cmd;

    typedef struct packed {
        logic ramp_due;
        logic ramp_more;
        logic out_last;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ src/lldr_in_if.sv @@
// request channel into the watchdog: valid/ready plus the input item fields
// depends on lldr_pkg for field widths
`default_nettype none

interface lldr_in_if;
    import lldr_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    logic [TIME_W-1:0]   now_ms;
    logic                got_packet;
    logic [CH_FLD_W-1:0] channel;
    logic [DUTY_W-1:0]   duty;

    modport source (
        output valid, operation, now_ms, got_packet, channel, duty,
        input  ready
    );
    modport sink (
        input  valid, operation, now_ms, got_packet, channel, duty,
        output ready
    );
endinterface

`default_nettype wire

@@ src/lldr_out_if.sv @@
// result channel out of the watchdog: valid/ready plus the result fields
// depends on lldr_pkg for field widths
`default_nettype none

interface lldr_out_if;
    import lldr_pkg::*;

    logic                valid;
    logic                ready;
    logic [CH_FLD_W-1:0] out_channel;
    logic [DUTY_W-1:0]   out_duty;
    logic                duty_valid;
    logic                stop_all;
    logic                safety_active;
    logic                entered_safety;
    logic                last;

    modport source (
        output valid, out_channel, out_duty, duty_valid, stop_all,
        output safety_active, entered_safety, last,
        input  ready
    );
    modport sink (
        input  valid, out_channel, out_duty, duty_valid, stop_all,
        input  safety_active, entered_safety, last,
        output ready
    );
endinterface

`default_nettype wire

@@ src/lldr_ctrl.sv @@
// controller state machine of the watchdog: sequences a loop pass and its ramp outputs
// depends on lldr_pkg (state enum, command and status structs)
`default_nettype none

module lldr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_op,
    input  wire logic              i_out_ready,
    input  wire lldr_pkg::t_dp_stat i_stat,
    output lldr_pkg::t_dp_cmd      o_cmd,
    output logic                   o_in_ready,
    output logic                   o_out_valid
);
    import lldr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    // a duty record is written on accept and causes no result
                    if (i_in_op != OP_RECORD) begin
                        n_state = S_TMO;
                    end
                end
            end
            S_TMO: begin
                o_cmd.tmo_update = 1'b1;
                n_state          = S_RAMP;
            end
            S_RAMP: begin
                if (i_stat.ramp_due && i_stat.ramp_more) begin
                    o_cmd.ramp_step = 1'b1;
                    n_state         = S_MUL;
                end else if (i_stat.ramp_due) begin
                    o_cmd.ramp_stop = 1'b1;
                    n_state         = S_OUT;
                end else begin
                    o_cmd.out_plain = 1'b1;
                    n_state         = S_OUT;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next_ch = 1'b1;
                        n_state       = S_MUL;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/lldr_dp.sv @@
// datapath of the watchdog: config registers, link timers, noise counter, duty stores,
// ramp multiply and reciprocal divide, result register; depends on lldr_pkg
`default_nettype none

module lldr_dp #(
    parameter int unsigned CHANNELS   = 8,
    parameter int unsigned RAMP_STEPS = 20
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lldr_pkg::t_dp_cmd                   i_cmd,
    input  wire lldr_pkg::t_in_item                  i_item,
    input  wire logic                                i_cfg_we,
    input  wire logic [lldr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [lldr_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    output lldr_pkg::t_dp_stat                       o_stat,
    output lldr_pkg::t_out_item                      o_item
);
    import lldr_pkg::*;

    localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0]   LAST_IDX = CH_W'(CHANNELS - 1);
    localparam logic [CH_FLD_W:0] CH_LIMIT = (CH_FLD_W + 1)'(CHANNELS);
    localparam logic [STEP_W-1:0] STEPS    = STEP_W'(RAMP_STEPS);
    localparam logic [DIV_MUL_W-1:0] DIV_MUL =
        DIV_MUL_W'(((64'd1 << DIV_SHIFT) + 64'(RAMP_STEPS) - 64'd1) / 64'(RAMP_STEPS));

    // configuration
    logic [15:0]         r_timeout;
    logic [7:0]          r_noise_passes;
    logic [15:0]         r_interval;

    // watchdog state
    logic [TIME_W-1:0]   r_last_pkt;
    logic [7:0]          r_noise;
    logic                r_safe;
    logic                r_entered;
    logic [STEP_W-1:0]   r_step;
    logic [TIME_W-1:0]   r_last_ramp;
    logic [DUTY_W-1:0]   r_cur  [CHANNELS];
    logic [DUTY_W-1:0]   r_backup [CHANNELS];

    // working registers
    t_in_item            r_item;
    logic [STEP_W-1:0]   r_factor;
    logic [CH_W-1:0]     r_idx;
    logic [PROD_W-1:0]   r_prod;
    t_out_item           r_out;

    logic [TIME_W-1:0]   elapsed;
    logic [TIME_W-1:0]   ramp_elapsed;
    logic                timed_out;
    logic [7:0]          noise_base;
    logic [7:0]          noise_inc;
    logic                safe_base;
    logic                enter;
    logic [STEP_W-1:0]   step_inc;
    logic [PROD_W+DIV_MUL_W-1:0] quo_full;
    logic [DUTY_W-1:0]   quo;
    logic                rec_ok;

    assign elapsed      = r_item.now_ms - r_last_pkt;
    assign timed_out    = elapsed > {16'd0, r_timeout};
    assign noise_base   = r_item.got_packet ? 8'd0 : r_noise;
    assign safe_base    = r_item.got_packet ? 1'b0 : r_safe;
    assign noise_inc    = (noise_base < r_noise_passes) ? 8'(noise_base + 8'd1) : noise_base;
    assign enter        = timed_out && (noise_inc >= r_noise_passes) && !safe_base;
    assign ramp_elapsed = r_item.now_ms - r_last_ramp;
    assign step_inc     = STEP_W'(r_step + 8'd1);
    assign quo_full     = {{DIV_MUL_W{1'b0}}, r_prod} * {{PROD_W{1'b0}}, DIV_MUL};
    assign quo          = quo_full[DIV_SHIFT +: DUTY_W];
    assign rec_ok       = ({1'b0, i_item.channel} < CH_LIMIT);

    assign o_stat.ramp_due  = r_safe && (ramp_elapsed >= {16'd0, r_interval});
    assign o_stat.ramp_more = r_step < STEPS;
    assign o_stat.out_last  = r_out.last;
    assign o_item           = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout      <= RST_TIMEOUT;
            r_noise_passes <= RST_NOISE;
            r_interval     <= RST_INTERVAL;
            r_last_pkt     <= '0;
            r_noise        <= '0;
            r_safe         <= 1'b0;
            r_entered      <= 1'b0;
            r_step         <= '0;
            r_last_ramp    <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_cur[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIMEOUT:  r_timeout      <= i_cfg_data;
                    CFG_NOISE:    r_noise_passes <= i_cfg_data[7:0];
                    CFG_INTERVAL: r_interval     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept && i_item.operation == OP_RECORD && rec_ok) begin
                r_cur[i_item.channel[CH_W-1:0]] <= i_item.duty;
            end
            if (i_cmd.tmo_update) begin
                // packet restamp uses the elapsed time taken before it
                if (r_item.got_packet) begin
                    r_last_pkt <= r_item.now_ms;
                end
                r_noise   <= timed_out ? noise_inc : noise_base;
                r_safe    <= safe_base || enter;
                r_entered <= enter;
                if (enter || (r_item.got_packet && r_safe)) begin
                    r_step <= '0;
                end
            end
            if (i_cmd.ramp_step) begin
                r_step      <= step_inc;
                r_last_ramp <= r_item.now_ms;
            end
            if (i_cmd.ramp_stop) begin
                r_last_ramp <= r_item.now_ms;
                for (int i = 0; i < CHANNELS; i++) begin
                    r_cur[i] <= '0;
                end
            end
            if (i_cmd.div) begin
                r_cur[r_idx] <= quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
        end
        if (i_cmd.tmo_update && enter) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_backup[i] <= r_cur[i];
            end
        end
        if (i_cmd.ramp_step) begin
            r_factor <= STEP_W'(STEPS - step_inc);
            r_idx    <= '0;
        end
        if (i_cmd.next_ch) begin
            r_idx <= CH_W'(r_idx + 1'b1);
        end
        if (i_cmd.mul) begin
            r_prod <= {{DUTY_W{1'b0}}, r_backup[r_idx]} * {{(PROD_W-STEP_W){1'b0}}, r_factor};
        end
        if (i_cmd.out_plain) begin
            r_out.out_channel    <= '0;
            r_out.out_duty       <= '0;
            r_out.duty_valid     <= 1'b0;
            r_out.stop_all       <= 1'b0;
            r_out.safety_active  <= r_safe;
            r_out.entered_safety <= r_entered;
            r_out.last           <= 1'b1;
        end
        if (i_cmd.ramp_stop) begin
            r_out.out_channel    <= '0;
            r_out.out_duty       <= '0;
            r_out.duty_valid     <= 1'b0;
            r_out.stop_all       <= 1'b1;
            r_out.safety_active  <= r_safe;
            r_out.entered_safety <= r_entered;
            r_out.last           <= 1'b1;
        end
        if (i_cmd.div) begin
            r_out.out_channel    <= CH_FLD_W'(r_idx);
            r_out.out_duty       <= quo;
            r_out.duty_valid     <= 1'b1;
            r_out.stop_all       <= 1'b0;
            r_out.safety_active  <= r_safe;
            r_out.entered_safety <= r_entered;
            r_out.last           <= (r_idx == LAST_IDX);
        end
    end

endmodule

`default_nettype wire

@@ src/link_loss_watchdog_ramp_down.sv @@
// top level of the link-loss watchdog with ramp-down soft stop
// depends on lldr_pkg, lldr_in_if, lldr_out_if, lldr_ctrl and lldr_dp
//
// usage:
//   i_in carries requests: a duty record (operation 1) stores one channel's
//   duty and produces no result; a loop pass (operation 0) carries the ms
//   timestamp and the packet flag and produces one or more results on o_out.
//   a loop pass gives one plain result, one stop-all result, or CHANNELS ramped
//   duty results in channel order; the final one has last set.
//   configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data):
//   0 timeout_ms, 1 noise_passes, 2 step_interval_ms; write only while idle.
// timing:
//   a duty record is taken in the idle state. a loop pass is accepted, then
//   passes the timeout and ramp check states before its first result is shown.
//   each ramped duty passes the multiply, reciprocal divide and output
//   register states in that order; a plain or stop-all pass goes from the
//   ramp check straight to the output state.
//   one request is in flight at a time; i_in.ready is high only while idle,
//   and the next request is taken the cycle after the final result.
// reset and stalls:
//   synchronous active-low reset restores register defaults (500, 5, 10) and
//   clears timers, counters, safe mode and the current duties. a result stays
//   in the output register until o_out.ready is seen; the block waits meanwhile.
`default_nettype none

module link_loss_watchdog_ramp_down #(
    parameter int unsigned CHANNELS   = 8,
    parameter int unsigned RAMP_STEPS = 20
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    lldr_in_if.sink                             i_in,
    lldr_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [lldr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lldr_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import lldr_pkg::*;

    t_dp_cmd   cmd;
    t_dp_stat  stat;
    t_in_item  in_item;
    t_out_item out_item;
    logic      in_ready;
    logic      out_valid;

    // gather the request fields into one item
    assign in_item.operation  = i_in.operation;
    assign in_item.now_ms     = i_in.now_ms;
    assign in_item.got_packet = i_in.got_packet;
    assign in_item.channel    = i_in.channel;
    assign in_item.duty       = i_in.duty;

    lldr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.operation),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid)
    );

    lldr_dp #(
        .CHANNELS   (CHANNELS),
        .RAMP_STEPS (RAMP_STEPS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_item     (out_item)
    );

    assign i_in.ready           = in_ready;
    assign o_out.valid          = out_valid;
    assign o_out.out_channel    = out_item.out_channel;
    assign o_out.out_duty       = out_item.out_duty;
    assign o_out.duty_valid     = out_item.duty_valid;
    assign o_out.stop_all       = out_item.stop_all;
    assign o_out.safety_active  = out_item.safety_active;
    assign o_out.entered_safety = out_item.entered_safety;
    assign o_out.last           = out_item.last;

    // one request in flight: no new request while a result is shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("request accepted while a result is pending");

    // a result is either a ramp duty or a stop-all, never both
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.duty_valid && o_out.stop_all))
        else $error("result marked as duty and stop-all");

    // ramp outputs only come out of safe mode
    a_ramp_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.duty_valid || o_out.stop_all || o_out.entered_safety))
        |-> o_out.safety_active)
        else $error("ramp result outside safe mode");

    // after the final result of a pass the block is ready for the next request
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> i_in.ready)
        else $error("block not idle after final result");

endmodule

`default_nettype wire

@@ test/lldr_watchdog_checker.sv @@
// checker for the link-loss watchdog: watches the request, result and config ports,
// predicts every result from its own copy of the watchdog state and compares.
// depends on lldr_pkg, lldr_in_if and lldr_out_if
module lldr_watchdog_checker #(
    parameter int unsigned CHANNELS   = 8,
    parameter int unsigned RAMP_STEPS = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lldr_in_if                             i_req,
    lldr_out_if                            i_res,
    input  logic                           i_cfg_we,
    input  lldr_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [lldr_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                           i_run_over,
    output int                             o_fail_count,
    output int                             o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import lldr_pkg::*;

    logic [15:0] cfg_timeout;
    logic [7:0]  cfg_noise;
    logic [15:0] cfg_interval;

    logic [31:0] link_pkt_ms;
    logic [31:0] ramp_last_ms;
    logic [7:0]  noise_cnt;
    logic [7:0]  ramp_pos;
    logic        safe_on;
    logic [7:0]  duty_saved [CHANNELS];
    logic [7:0]  duty_now [CHANNELS];

    t_out_item watchdog_results_q[$];

    int   mismatch_cnt  = 0;
    int   requests_seen = 0;
    int   ramp_steps    = 0;
    int   stop_passes   = 0;
    int   safe_entries  = 0;
    logic summary_done  = 1'b0;

    function automatic void note_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // one loop pass: timeout counting, safe-mode entry and the ramp action
    function automatic void apply_loop_pass(logic [31:0] now, logic pkt);
        logic [31:0] since_pkt;
        logic [31:0] since_ramp;
        logic        entered;
        int unsigned scaled;
        t_out_item   r;
        since_pkt = now - link_pkt_ms;
        entered   = 1'b0;
        if (pkt) begin
            link_pkt_ms = now;
            noise_cnt   = '0;
            if (safe_on) begin
                safe_on  = 1'b0;
                ramp_pos = '0;
            end
        end
        // elapsed time was taken before the restamp
        if (since_pkt > {16'd0, cfg_timeout}) begin
            if (noise_cnt < cfg_noise) noise_cnt++;
            if (noise_cnt >= cfg_noise && !safe_on) begin
                safe_on  = 1'b1;
                ramp_pos = '0;
                entered  = 1'b1;
                safe_entries++;
                for (int c = 0; c < CHANNELS; c++) duty_saved[c] = duty_now[c];
            end
        end
        r = '0;
        r.safety_active  = safe_on;
        r.entered_safety = entered;
        since_ramp = now - ramp_last_ms;
        if (safe_on && since_ramp >= {16'd0, cfg_interval}) begin
            ramp_last_ms = now;
            if (ramp_pos < RAMP_STEPS) begin
                ramp_pos++;
                ramp_steps++;
                for (int c = 0; c < CHANNELS; c++) begin
                    scaled = (duty_saved[c] * (RAMP_STEPS - ramp_pos)) / RAMP_STEPS;
                    duty_now[c]   = scaled[7:0];
                    r.out_channel = c[CH_FLD_W-1:0];
                    r.out_duty    = scaled[DUTY_W-1:0];
                    r.duty_valid  = 1'b1;
                    r.last        = (c == CHANNELS - 1);
                    watchdog_results_q.push_back(r);
                end
            end else begin
                for (int c = 0; c < CHANNELS; c++) duty_now[c] = '0;
                stop_passes++;
                r.stop_all = 1'b1;
                r.last     = 1'b1;
                watchdog_results_q.push_back(r);
            end
        end else begin
            r.last = 1'b1;
            watchdog_results_q.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cfg_timeout  = RST_TIMEOUT;
            cfg_noise    = RST_NOISE;
            cfg_interval = RST_INTERVAL;
            link_pkt_ms  = '0;
            ramp_last_ms = '0;
            noise_cnt    = '0;
            ramp_pos     = '0;
            safe_on      = 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                duty_saved[c] = '0;
                duty_now[c]   = '0;
            end
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (watchdog_results_q.size() == 0) begin
                    $error("unexpected result: channel %0d duty %0d stop_all %0d",
                           i_res.out_channel, i_res.out_duty, i_res.stop_all);
                    mismatch_cnt++;
                end else begin
                    want = watchdog_results_q.pop_front();
                    note_field("out_channel", want.out_channel, i_res.out_channel);
                    note_field("out_duty", want.out_duty, i_res.out_duty);
                    note_field("duty_valid", want.duty_valid, i_res.duty_valid);
                    note_field("stop_all", want.stop_all, i_res.stop_all);
                    note_field("safety_active", want.safety_active, i_res.safety_active);
                    note_field("entered_safety", want.entered_safety, i_res.entered_safety);
                    note_field("last", want.last, i_res.last);
                end
            end
            if (i_req.valid && i_req.ready) begin
                requests_seen++;
                if (i_req.operation == OP_RECORD) begin
                    if (i_req.channel < CHANNELS) duty_now[i_req.channel] = i_req.duty;
                end else begin
                    apply_loop_pass(i_req.now_ms, i_req.got_packet);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIMEOUT:  cfg_timeout  = i_cfg_data;
                    CFG_NOISE:    cfg_noise    = i_cfg_data[7:0];
                    CFG_INTERVAL: cfg_interval = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_run_over && !summary_done) begin
                summary_done = 1'b1;
                if (watchdog_results_q.size() != 0) begin
                    $error("%0d expected results never arrived", watchdog_results_q.size());
                    mismatch_cnt += watchdog_results_q.size();
                end
                $display("covered %0d requests, %0d ramp steps, %0d stop-all passes,",
                         requests_seen, ramp_steps, stop_passes);
                $display("%0d safe-mode entries over several timeout/noise/interval settings",
                         safe_entries);
            end
        end
        o_fail_count  <= mismatch_cnt;
        o_outstanding <= watchdog_results_q.size();
    end

endmodule

@@ test/link_loss_watchdog_ramp_down_test.sv @@
// testbench top for the link-loss watchdog with ramp-down: drives requests, config
// writes and result back-pressure, and reports the verdict of lldr_watchdog_checker
// depends on lldr_pkg, lldr_in_if, lldr_out_if, the block and the checker
module link_loss_watchdog_ramp_down_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lldr_pkg::*;

    localparam int unsigned N_CH          = 8;
    localparam int unsigned N_STEPS       = 20;
    localparam int unsigned IDLE_LIMIT    = 2000;  // cycles without any handshake
    localparam int unsigned SETTLE_CYCLES = 6;     // a duty record gives no result
    localparam int unsigned TAIL_CYCLES   = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    t_cfg_idx             cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 run_over;
    logic                 quiet;        // stretch with no idling on either side
    int                   fail_count;
    int                   outstanding;

    // free-running link clock of the stimulus and the settings in force
    logic [31:0]          ms_clock;
    logic [15:0]          cur_timeout;
    logic [15:0]          cur_interval;
    int unsigned          sent_items  = 0;
    int unsigned          idle_cycles = 0;

    lldr_in_if  req_ch ();
    lldr_out_if res_ch ();

    link_loss_watchdog_ramp_down #(
        .CHANNELS   (N_CH),
        .RAMP_STEPS (N_STEPS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (req_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lldr_watchdog_checker #(
        .CHANNELS   (N_CH),
        .RAMP_STEPS (N_STEPS)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_run_over    (run_over),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: the run is hung if neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("no handshake for %0d cycles, stopping", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: a random stall before each result is taken, none while quiet
    initial begin
        int unsigned stall;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // one request; valid stays up when the next one follows without a gap
    task automatic send_request(logic op, logic [31:0] now, logic pkt,
                                logic [2:0] ch, logic [7:0] duty);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 14) == 0) quiet <= ~quiet;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.now_ms     <= now;
        req_ch.got_packet <= pkt;
        req_ch.channel    <= ch;
        req_ch.duty       <= duty;
        do @(posedge i_clk); while (!req_ch.ready);
        sent_items++;
    endtask

    // unused fields carry random junk so every bit toggles
    task automatic loop_pass(logic [31:0] now, logic pkt);
        send_request(OP_LOOP, now, pkt, 3'($urandom), 8'($urandom));
    endtask

    task automatic duty_record(logic [2:0] ch, logic [7:0] duty);
        send_request(OP_RECORD, $urandom, 1'($urandom), ch, duty);
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic quiesce();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [15:0] tmo, logic [7:0] passes, logic [15:0] step_ms);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_TIMEOUT;
        cfg_data <= tmo;
        @(posedge i_clk);
        cfg_idx  <= CFG_NOISE;
        cfg_data <= {8'd0, passes};
        @(posedge i_clk);
        cfg_idx  <= CFG_INTERVAL;
        cfg_data <= step_ms;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cur_timeout  = tmo;
        cur_interval = step_ms;
    endtask

    function automatic logic [7:0] pick_duty();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // time between passes during link loss: mostly a full ramp interval
    function automatic logic [31:0] step_gap();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1, 2:    return $urandom_range(0, cur_interval);
            default: return cur_interval + $urandom_range(0, 5);
        endcase
    endfunction

    // healthy link, then a loss long enough to time out and often to ramp
    // down fully, with noise and stray packets mixed in, then recovery
    task automatic link_episode();
        int unsigned n_rec;
        int unsigned n_ok;
        int unsigned n_lost;
        n_rec = $urandom_range(0, 3);
        repeat (n_rec) duty_record(3'($urandom), pick_duty());
        n_ok = $urandom_range(1, 3);
        repeat (n_ok) begin
            ms_clock += $urandom_range(0, 20);
            loop_pass(ms_clock, $urandom_range(0, 5) != 0);
        end
        n_lost = ($urandom_range(0, 9) < 4) ? $urandom_range(22, 30) : $urandom_range(2, 12);
        ms_clock += cur_timeout + $urandom_range(1, 40);
        for (int k = 0; k < n_lost; k++) begin
            case ($urandom_range(0, 19))
                0: loop_pass($urandom, 1'($urandom));
                1: duty_record(3'($urandom), pick_duty());
                2: begin
                    ms_clock += step_gap();
                    loop_pass(ms_clock, 1'b1);
                end
                default: begin
                    if (k != 0) ms_clock += step_gap();
                    loop_pass(ms_clock, 1'b0);
                end
            endcase
        end
        ms_clock += $urandom_range(0, 20);
        loop_pass(ms_clock, 1'b1);
    endtask

    task automatic random_phase(logic [15:0] tmo, logic [7:0] passes,
                                logic [15:0] step_ms, int unsigned quota);
        int unsigned start;
        quiesce();
        set_regs(tmo, passes, step_ms);
        start    = sent_items;
        ms_clock = $urandom;
        while (sent_items - start < quota) link_episode();
    endtask

    initial begin
        // every block input known from time zero
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_TIMEOUT;
        cfg_data          = '0;
        run_over          = 1'b0;
        quiet             = 1'b0;
        ms_clock          = '0;
        cur_timeout       = RST_TIMEOUT;
        cur_interval      = RST_INTERVAL;
        req_ch.valid      = 1'b0;
        req_ch.operation  = OP_LOOP;
        req_ch.now_ms     = '0;
        req_ch.got_packet = 1'b0;
        req_ch.channel    = '0;
        req_ch.duty       = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset settings: timeout 500, 5 noise passes, interval 10
        duty_record(3'd0, 8'd255);
        duty_record(3'd7, 8'd0);
        duty_record(3'd3, 8'd128);
        duty_record(3'd1, 8'd1);
        loop_pass(32'd0, 1'b0);             // nothing elapsed
        loop_pass(32'd500, 1'b0);           // exactly at the timeout, no count
        loop_pass(32'd501, 1'b1);           // packet on a timed-out pass still counts
        for (int k = 0; k < 4; k++) begin
            loop_pass(32'd1002 + k, 1'b0);  // fifth count enters safe mode, first step
        end
        loop_pass(32'd1010, 1'b0);          // inside the step interval: plain result
        loop_pass(32'd1015, 1'b0);          // second ramp step
        loop_pass(32'd1016, 1'b1);          // packet leaves safe mode
        loop_pass(32'hFFFF_FFFF, 1'b0);     // top of the timestamp range
        loop_pass(32'd0, 1'b1);             // timestamp wraps

        // random part over several settings, extremes included
        random_phase(16'd0, 8'd0, 16'd0, 14);
        random_phase(16'hFFFF, 8'd255, 16'hFFFF, 8);
        random_phase(16'($urandom_range(1, 2000)), 8'($urandom_range(1, 8)),
                     16'($urandom_range(1, 50)), 14);
        random_phase(16'($urandom_range(0, 100)), 8'd1, 16'd1, 10);
        random_phase(16'($urandom), 8'($urandom_range(1, 4)), 16'hFFFF, 10);

        quiesce();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        run_over <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
